// ===== hdl/glyph_layout_cursor_engine_defines.svh =====
// Assertion helpers for the glyph layout cursor engine.
// Each macro expects clk and rst to be in scope.
`ifndef GLYPH_LAYOUT_CURSOR_ENGINE_DEFINES_SVH
`define GLYPH_LAYOUT_CURSOR_ENGINE_DEFINES_SVH

// same-cycle implication
`define GLC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define GLC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/glc_pkg.sv =====
`default_nettype none

package glc_pkg;

  localparam int COORD_BITS  = 16;
  localparam int METRIC_BITS = 8;
  localparam int CODE_BITS   = 21;
  // exact edge math: pen + two metrics + one metric fits in three extra bits
  localparam int WIDE_BITS   = COORD_BITS + 3;
  localparam int CFG_IDX_BITS = 3;

  typedef logic signed [COORD_BITS-1:0]  coord_t;
  typedef logic signed [WIDE_BITS-1:0]   wide_t;
  typedef logic signed [METRIC_BITS-1:0] smetric_t;
  typedef logic        [METRIC_BITS-1:0] umetric_t;
  typedef logic        [CODE_BITS-1:0]   code_t;

  localparam coord_t COORD_MAX = coord_t'({1'b0, {(COORD_BITS-1){1'b1}}});
  localparam coord_t COORD_MIN = ~COORD_MAX;
  localparam wide_t  WIDE_CMAX = wide_t'(COORD_MAX);
  localparam wide_t  WIDE_CMIN = wide_t'(COORD_MIN);

  localparam code_t CODE_NONE    = '0;
  localparam code_t NEWLINE_CODE = code_t'(10);

  // actions
  localparam logic [1:0] ACT_PLACE      = 2'd0;
  localparam logic [1:0] ACT_NEWLINE    = 2'd1;
  localparam logic [1:0] ACT_CURSOR     = 2'd2;
  localparam logic [1:0] ACT_USED_RESET = 2'd3;

  // status
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // right / bottom edge modes
  localparam logic [1:0] RIGHT_WRAP  = 2'd0;
  localparam logic [1:0] RIGHT_TRIM  = 2'd1;
  localparam logic [1:0] RIGHT_ERROR = 2'd2;
  localparam logic [1:0] RIGHT_NONE  = 2'd3;
  localparam logic       BOTTOM_TRIM = 1'b0;

  // config register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_BOX_LEFT    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_BOX_TOP     = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_BOX_RIGHT   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_BOX_BOTTOM  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_LINE_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_RIGHT_MODE  = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_BOTTOM_MODE = 3'd6;

  typedef struct packed {
    logic [1:0] action;
    code_t      codepoint;
    logic       glyph_found;
    umetric_t   glyph_width;
    umetric_t   glyph_height;
    smetric_t   x_offset;
    smetric_t   y_offset;
    smetric_t   x_advance;
    smetric_t   kern_amount;
    coord_t     cursor_x;
    coord_t     cursor_y;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       draw_valid;
    coord_t     quad_left;
    coord_t     quad_top;
    coord_t     quad_right;
    coord_t     quad_bottom;
    coord_t     pen_x_out;
    coord_t     pen_y_out;
    coord_t     used_left_out;
    coord_t     used_top_out;
    coord_t     used_right_out;
    coord_t     used_bottom_out;
  } out_item_t;

  typedef struct packed {
    coord_t     left_edge;
    coord_t     box_top;
    coord_t     right_edge;
    coord_t     bottom_edge;
    umetric_t   line_step;
    logic [1:0] right_policy;
    logic       bottom_policy;
  } cfg_t;

  typedef struct packed {
    coord_t pen_x;
    coord_t pen_y;
    code_t  last_code;
    coord_t ink_left;
    coord_t ink_top;
    coord_t ink_right;
    coord_t ink_bottom;
  } state_t;

  function automatic coord_t sat_coord(input wide_t v);
    coord_t r;
    if (v > WIDE_CMAX) begin
      r = COORD_MAX;
    end else if (v < WIDE_CMIN) begin
      r = COORD_MIN;
    end else begin
      r = v[COORD_BITS-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/glc_cfg_regs.sv =====
`default_nettype none

module glc_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             wr_en,
  input  wire logic [glc_pkg::CFG_IDX_BITS-1:0] wr_index,
  input  wire logic [glc_pkg::COORD_BITS-1:0]   wr_data,
  output glc_pkg::cfg_t                         cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.left_edge     <= '0;
      cfg.box_top       <= '0;
      cfg.right_edge    <= glc_pkg::COORD_MAX;
      cfg.bottom_edge   <= glc_pkg::COORD_MAX;
      cfg.line_step     <= '0;
      cfg.right_policy  <= glc_pkg::RIGHT_WRAP;
      cfg.bottom_policy <= glc_pkg::BOTTOM_TRIM;
    end else if (wr_en) begin
      unique case (wr_index)
        glc_pkg::REG_BOX_LEFT:    cfg.left_edge     <= wr_data;
        glc_pkg::REG_BOX_TOP:     cfg.box_top       <= wr_data;
        glc_pkg::REG_BOX_RIGHT:   cfg.right_edge    <= wr_data;
        glc_pkg::REG_BOX_BOTTOM:  cfg.bottom_edge   <= wr_data;
        glc_pkg::REG_LINE_HEIGHT: cfg.line_step     <= wr_data[glc_pkg::METRIC_BITS-1:0];
        glc_pkg::REG_RIGHT_MODE:  cfg.right_policy  <= wr_data[1:0];
        glc_pkg::REG_BOTTOM_MODE: cfg.bottom_policy <= wr_data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/glc_place.sv =====
`default_nettype none

// One item against the current pen / used-box state: next state plus result.
module glc_place (
  input  wire glc_pkg::in_item_t item,
  input  wire glc_pkg::state_t   cur,
  input  wire glc_pkg::cfg_t     cfg,
  output glc_pkg::state_t        nxt,
  output glc_pkg::out_item_t     res
);

  glc_pkg::wide_t px, py, bl, br, bb, lh;
  glc_pkg::wide_t gw, gh, xoff, yoff, adv, kern;
  glc_pkg::wide_t x1a, x2a, y1a, y2a;
  glc_pkg::wide_t x1w, x2w, y1w, y2w;
  glc_pkg::wide_t x1, x2, y1, y2, pen_y_eff;
  glc_pkg::coord_t nl_pen_y, adv_pen_x, wrap_pen_x;
  glc_pkg::coord_t qx1, qy1, qx2, qy2;
  logic wrap, full;

  always_comb begin
    px   = glc_pkg::wide_t'(cur.pen_x);
    py   = glc_pkg::wide_t'(cur.pen_y);
    bl   = glc_pkg::wide_t'(cfg.left_edge);
    br   = glc_pkg::wide_t'(cfg.right_edge);
    bb   = glc_pkg::wide_t'(cfg.bottom_edge);
    lh   = glc_pkg::wide_t'(cfg.line_step);
    gw   = glc_pkg::wide_t'(item.glyph_width);
    gh   = glc_pkg::wide_t'(item.glyph_height);
    xoff = glc_pkg::wide_t'(item.x_offset);
    yoff = glc_pkg::wide_t'(item.y_offset);
    adv  = glc_pkg::wide_t'(item.x_advance);
    kern = glc_pkg::wide_t'(item.kern_amount);

    nl_pen_y = glc_pkg::sat_coord(py + lh);

    // quad at the current pen, with kerning
    x1a = px + xoff + kern;
    x2a = x1a + gw;
    y1a = py + yoff;
    y2a = y1a + gh;
    adv_pen_x = glc_pkg::sat_coord(px + adv + kern);

    // quad after a wrap to the next line, no kerning
    x1w = bl + xoff;
    x2w = x1w + gw;
    y1w = glc_pkg::wide_t'(nl_pen_y) + yoff;
    y2w = y1w + gh;
    wrap_pen_x = glc_pkg::sat_coord(bl + adv);

    wrap = 1'b0;
    full = 1'b0;
    x1 = x1a;
    x2 = x2a;
    y1 = y1a;
    y2 = y2a;

    case (cfg.right_policy)
      glc_pkg::RIGHT_WRAP: begin
        if (x2a >= br) begin
          wrap = 1'b1;
          x1 = x1w;
          x2 = x2w;
          y1 = y1w;
          y2 = y2w;
        end
      end
      glc_pkg::RIGHT_TRIM: begin
        if (x1a >= br) begin
          full = 1'b1;
        end else if (x2a > br) begin
          x2 = br;
        end
      end
      glc_pkg::RIGHT_ERROR: begin
        if (x2a > br) begin
          full = 1'b1;
        end
      end
      default: ;
    endcase

    pen_y_eff = wrap ? glc_pkg::wide_t'(nl_pen_y) : py;

    if (!full) begin
      if (cfg.bottom_policy == glc_pkg::BOTTOM_TRIM) begin
        if (pen_y_eff >= bb) begin
          full = 1'b1;
        end else if (y2 > bb) begin
          y2 = bb;
        end
      end else if (y2 > bb) begin
        full = 1'b1;
      end
    end

    qx1 = glc_pkg::sat_coord(x1);
    qy1 = glc_pkg::sat_coord(y1);
    qx2 = glc_pkg::sat_coord(x2);
    qy2 = glc_pkg::sat_coord(y2);

    nxt = cur;
    res = '0;
    res.status = glc_pkg::ST_OK;

    unique case (item.action)
      glc_pkg::ACT_NEWLINE: begin
        nxt.pen_x = cfg.left_edge;
        nxt.pen_y = nl_pen_y;
      end
      glc_pkg::ACT_CURSOR: begin
        nxt.pen_x     = item.cursor_x;
        nxt.pen_y     = item.cursor_y;
        nxt.last_code = glc_pkg::CODE_NONE;
      end
      glc_pkg::ACT_USED_RESET: begin
        nxt.ink_left   = glc_pkg::COORD_MAX;
        nxt.ink_top    = glc_pkg::COORD_MAX;
        nxt.ink_right  = '0;
        nxt.ink_bottom = '0;
      end
      default: begin
        if (item.codepoint == glc_pkg::CODE_NONE) begin
          res.status = glc_pkg::ST_INVALID;
        end else if (item.codepoint == glc_pkg::NEWLINE_CODE) begin
          nxt.pen_x = cfg.left_edge;
          nxt.pen_y = nl_pen_y;
        end else if (!item.glyph_found) begin
          res.status = glc_pkg::ST_NOTFOUND;
        end else begin
          // pen advance sticks even when the glyph ends up not fitting
          nxt.pen_x = wrap ? wrap_pen_x : adv_pen_x;
          if (wrap) begin
            nxt.pen_y = nl_pen_y;
          end
          if (full) begin
            res.status = glc_pkg::ST_FULL;
          end else begin
            if (cur.ink_left > qx1) nxt.ink_left = qx1;
            if (cur.ink_top > qy1) nxt.ink_top = qy1;
            if (cur.ink_right < qx2) nxt.ink_right = qx2;
            if (cur.ink_bottom < qy2) nxt.ink_bottom = qy2;
            nxt.last_code   = item.codepoint;
            res.draw_valid  = 1'b1;
            res.quad_left   = qx1;
            res.quad_top    = qy1;
            res.quad_right  = qx2;
            res.quad_bottom = qy2;
          end
        end
      end
    endcase

    res.pen_x_out       = nxt.pen_x;
    res.pen_y_out       = nxt.pen_y;
    res.used_left_out   = nxt.ink_left;
    res.used_top_out    = nxt.ink_top;
    res.used_right_out  = nxt.ink_right;
    res.used_bottom_out = nxt.ink_bottom;
  end

endmodule

`default_nettype wire

// ===== hdl/glyph_layout_cursor_engine.sv =====
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_stall    in_item  (glc_pkg::in_item_t)
// out       output     out_valid / out_stall  out_item (glc_pkg::out_item_t)
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per cycle sustained while out_stall stays low; a beat taken on in passes
// through the input register, then placement logic into the result register.
// Pen, last codepoint and used box update as an item moves into the result register.
// Synchronous reset clears the stages and loads register and state defaults.
// out_stall holds the result register; in_stall rises when the input register
// is full and cannot move on. cfg_ready is always high.
`default_nettype none
`include "glyph_layout_cursor_engine_defines.svh"

module glyph_layout_cursor_engine (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire glc_pkg::in_item_t                in_item,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output glc_pkg::out_item_t                    out_item,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [glc_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [glc_pkg::COORD_BITS-1:0]   cfg_data
);

  glc_pkg::cfg_t      cfg;
  glc_pkg::state_t    state;
  glc_pkg::state_t    state_next;
  glc_pkg::in_item_t  stage_item;
  glc_pkg::out_item_t result;
  logic               stage_valid;
  logic               advance;
  logic               draw_beat;
  logic               blank_beat;
  logic               status_ok;
  logic               quad_zero;
  logic               quad_in_ink;

  assign cfg_ready = 1'b1;
  assign advance   = stage_valid && (!out_valid || !out_stall);
  assign in_stall  = stage_valid && !advance;

  glc_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  glc_place u_place (
    .item (stage_item),
    .cur  (state),
    .cfg  (cfg),
    .nxt  (state_next),
    .res  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!in_stall) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      stage_item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.pen_x      <= '0;
      state.pen_y      <= '0;
      state.last_code  <= glc_pkg::CODE_NONE;
      state.ink_left   <= glc_pkg::COORD_MAX;
      state.ink_top    <= glc_pkg::COORD_MAX;
      state.ink_right  <= '0;
      state.ink_bottom <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= result;
    end
  end

  assign draw_beat   = out_valid && out_item.draw_valid;
  assign blank_beat  = out_valid && !out_item.draw_valid;
  assign status_ok   = (out_item.status == glc_pkg::ST_OK);
  assign quad_zero   = (out_item.quad_left == '0) && (out_item.quad_top == '0) &&
                       (out_item.quad_right == '0) && (out_item.quad_bottom == '0);
  assign quad_in_ink = (out_item.used_left_out <= out_item.quad_left) &&
                       (out_item.used_right_out >= out_item.quad_right) &&
                       (out_item.used_top_out <= out_item.quad_top) &&
                       (out_item.used_bottom_out >= out_item.quad_bottom);

  `GLC_ASSERT_NOW(a_draw_ok, draw_beat, status_ok, "draw beat without ok status")
  `GLC_ASSERT_NOW(a_no_quad, blank_beat, quad_zero, "quad not cleared on a beat without draw")
  `GLC_ASSERT_NOW(a_quad_in_used, draw_beat, quad_in_ink, "placed quad outside used box")
  `GLC_ASSERT_NEXT(a_advance_out, advance, out_valid, "result register not loaded after advance")

endmodule

`default_nettype wire

// ===== dv/glyph_layout_cursor_engine_checker.sv =====
module glyph_layout_cursor_engine_checker
  import glc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  in_item_t                in_item,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  out_item_t               out_item,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]   cfg_data,
  output int                      errors,
  output int                      pending
);

  // canvas registers as last written
  coord_t     left_edge, box_top, right_edge, bottom_edge;
  umetric_t   line_step;
  logic [1:0] right_policy;
  logic       bottom_policy;

  // cursor state
  coord_t     pen_x, pen_y;
  code_t      last_cp;
  coord_t     ink_left, ink_top, ink_right, ink_bottom;

  out_item_t  layout_due[$];
  out_item_t  want;

  function automatic coord_t clamp_coord(int v);
    if (v > int'(COORD_MAX)) return COORD_MAX;
    if (v < int'(COORD_MIN)) return COORD_MIN;
    return coord_t'(v);
  endfunction

  function automatic void clear_used();
    ink_left   = COORD_MAX;
    ink_top    = COORD_MAX;
    ink_right  = '0;
    ink_bottom = '0;
  endfunction

  function automatic void line_feed();
    pen_x = left_edge;
    pen_y = clamp_coord(int'(pen_y) + int'(line_step));
  endfunction

  // Moves the cursor for one item and builds the result the block owes for it.
  function automatic out_item_t advance_layout(in_item_t it);
    out_item_t  r;
    logic [1:0] st;
    logic       drew;
    int         x1, y1, x2, y2;
    int         xoff, yoff, adv, kern, gw, gh;
    coord_t     qx1, qy1, qx2, qy2;
    r    = '0;
    st   = ST_OK;
    drew = 1'b0;
    x1 = 0; y1 = 0; x2 = 0; y2 = 0;
    xoff = int'(it.x_offset);
    yoff = int'(it.y_offset);
    adv  = int'(it.x_advance);
    kern = int'(it.kern_amount);
    gw   = int'(it.glyph_width);
    gh   = int'(it.glyph_height);
    case (it.action)
      ACT_NEWLINE: line_feed();
      ACT_CURSOR: begin
        pen_x   = it.cursor_x;
        pen_y   = it.cursor_y;
        last_cp = CODE_NONE;
      end
      ACT_USED_RESET: clear_used();
      default: begin
        if (it.codepoint == CODE_NONE) begin
          st = ST_INVALID;
        end else if (it.codepoint == NEWLINE_CODE) begin
          line_feed();
        end else if (!it.glyph_found) begin
          st = ST_NOTFOUND;
        end else begin
          x1 = int'(pen_x) + xoff + kern;
          x2 = x1 + gw;
          y1 = int'(pen_y) + yoff;
          y2 = y1 + gh;
          // advance sticks even if the glyph is rejected below
          pen_x = clamp_coord(int'(pen_x) + adv + kern);
          case (right_policy)
            RIGHT_WRAP: begin
              if (x2 >= int'(right_edge)) begin
                line_feed();
                x1 = int'(left_edge) + xoff;
                x2 = x1 + gw;
                y1 = int'(pen_y) + yoff;
                y2 = y1 + gh;
                pen_x = clamp_coord(int'(left_edge) + adv);
              end
            end
            RIGHT_TRIM: begin
              if (x1 >= int'(right_edge)) begin
                st = ST_FULL;
              end else if (x2 > int'(right_edge)) begin
                x2 = int'(right_edge);
              end
            end
            RIGHT_ERROR: begin
              if (x2 > int'(right_edge)) st = ST_FULL;
            end
            default: ;
          endcase
          if (st == ST_OK) begin
            if (bottom_policy == BOTTOM_TRIM) begin
              if (int'(pen_y) >= int'(bottom_edge)) begin
                st = ST_FULL;
              end else if (y2 > int'(bottom_edge)) begin
                y2 = int'(bottom_edge);
              end
            end else if (y2 > int'(bottom_edge)) begin
              st = ST_FULL;
            end
          end
          if (st == ST_OK) begin
            qx1 = clamp_coord(x1);
            qy1 = clamp_coord(y1);
            qx2 = clamp_coord(x2);
            qy2 = clamp_coord(y2);
            if (ink_left > qx1) ink_left = qx1;
            if (ink_top > qy1) ink_top = qy1;
            if (ink_right < qx2) ink_right = qx2;
            if (ink_bottom < qy2) ink_bottom = qy2;
            last_cp = it.codepoint;
            drew = 1'b1;
            r.quad_left   = qx1;
            r.quad_top    = qy1;
            r.quad_right  = qx2;
            r.quad_bottom = qy2;
          end
        end
      end
    endcase
    r.status          = st;
    r.draw_valid      = drew;
    r.pen_x_out       = pen_x;
    r.pen_y_out       = pen_y;
    r.used_left_out   = ink_left;
    r.used_top_out    = ink_top;
    r.used_right_out  = ink_right;
    r.used_bottom_out = ink_bottom;
    return r;
  endfunction

  task automatic field_check(string name, coord_t e, coord_t a);
    if (a !== e) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, name, e, a);
    end
  endtask

  task automatic compare_beat(out_item_t w, out_item_t g);
    field_check("status", coord_t'(w.status), coord_t'(g.status));
    field_check("draw_valid", coord_t'(w.draw_valid), coord_t'(g.draw_valid));
    field_check("quad_left", w.quad_left, g.quad_left);
    field_check("quad_top", w.quad_top, g.quad_top);
    field_check("quad_right", w.quad_right, g.quad_right);
    field_check("quad_bottom", w.quad_bottom, g.quad_bottom);
    field_check("pen_x_out", w.pen_x_out, g.pen_x_out);
    field_check("pen_y_out", w.pen_y_out, g.pen_y_out);
    field_check("used_left_out", w.used_left_out, g.used_left_out);
    field_check("used_top_out", w.used_top_out, g.used_top_out);
    field_check("used_right_out", w.used_right_out, g.used_right_out);
    field_check("used_bottom_out", w.used_bottom_out, g.used_bottom_out);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      left_edge     = '0;
      box_top       = '0;
      right_edge    = COORD_MAX;
      bottom_edge   = COORD_MAX;
      line_step     = '0;
      right_policy  = RIGHT_WRAP;
      bottom_policy = BOTTOM_TRIM;
      pen_x         = '0;
      pen_y         = '0;
      last_cp       = CODE_NONE;
      clear_used();
      layout_due.delete();
      errors        = 0;
      pending      <= 0;
    end else begin
      if (cfg_valid === 1'b1 && cfg_ready === 1'b1) begin
        case (cfg_index)
          REG_BOX_LEFT:    left_edge     = coord_t'(cfg_data);
          REG_BOX_TOP:     box_top       = coord_t'(cfg_data);
          REG_BOX_RIGHT:   right_edge    = coord_t'(cfg_data);
          REG_BOX_BOTTOM:  bottom_edge   = coord_t'(cfg_data);
          REG_LINE_HEIGHT: line_step     = cfg_data[METRIC_BITS-1:0];
          REG_RIGHT_MODE:  right_policy  = cfg_data[1:0];
          REG_BOTTOM_MODE: bottom_policy = cfg_data[0];
          default: ;
        endcase
      end
      // pop before push: a beat can never come back in the cycle it was taken
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (layout_due.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing expected, got %h", $time, out_item);
        end else begin
          want = layout_due.pop_front();
          compare_beat(want, out_item);
        end
      end
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        layout_due.push_back(advance_layout(in_item));
      end
      pending <= layout_due.size();
    end
  end

endmodule

// ===== dv/glyph_layout_cursor_engine_tb.sv =====
module glyph_layout_cursor_engine_tb;
  import glc_pkg::*;

  localparam logic BOTTOM_ERROR = 1'b1;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  in_item_t                in_item = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  out_item_t               out_item;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [COORD_BITS-1:0]   cfg_data = '0;

  int errors;
  int pending;

  // canvas as last programmed, used to aim cursor moves
  int canvas_left, canvas_right, canvas_bottom;
  int burst_left = 0;

  int       stall_mode = 0;
  int       stall_left = 0;
  bit [3:0] stall_tick = '0;

  always #2 clk = ~clk;

  glyph_layout_cursor_engine dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  glyph_layout_cursor_engine_checker checker_i (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  // receiver: free-flowing, light, heavy and periodic stall stretches
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1'b1;
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(8, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= stall_tick[2];
    endcase
  end

  initial begin
    #2000000;
    $display("glyph_layout_cursor_engine_tb: done, errors");
    $finish;
  end

  function automatic in_item_t rand_item();
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  function automatic in_item_t mk_glyph(int code, bit found, int w, int h,
                                        int xo, int yo, int adv, int kern);
    in_item_t it;
    it = rand_item();
    it.action       = ACT_PLACE;
    it.codepoint    = code_t'(code);
    it.glyph_found  = found;
    it.glyph_width  = umetric_t'(w);
    it.glyph_height = umetric_t'(h);
    it.x_offset     = smetric_t'(xo);
    it.y_offset     = smetric_t'(yo);
    it.x_advance    = smetric_t'(adv);
    it.kern_amount  = smetric_t'(kern);
    return it;
  endfunction

  function automatic in_item_t mk_cursor(int x, int y);
    in_item_t it;
    it = rand_item();
    it.action   = ACT_CURSOR;
    it.cursor_x = coord_t'(x);
    it.cursor_y = coord_t'(y);
    return it;
  endfunction

  function automatic in_item_t mk_ctrl(logic [1:0] act);
    in_item_t it;
    it = rand_item();
    it.action = act;
    return it;
  endfunction

  // Mostly well-formed text: found glyphs with small metrics, line breaks and
  // cursor jumps near the edges; a few rejects and pure noise.
  function automatic in_item_t rand_layout_item();
    in_item_t it;
    int       pick;
    int       cx, cy;
    it   = rand_item();
    pick = $urandom_range(0, 99);
    if (pick < 62) begin
      it.action      = ACT_PLACE;
      it.glyph_found = 1'b1;
      if (it.codepoint == CODE_NONE || it.codepoint == NEWLINE_CODE) begin
        it.codepoint = code_t'(65);
      end
      if ($urandom_range(0, 1) == 0) it.kern_amount = '0;
      if ($urandom_range(0, 2) != 0) begin
        it.glyph_width  = umetric_t'($urandom_range(0, 24));
        it.glyph_height = umetric_t'($urandom_range(0, 32));
        it.x_offset     = smetric_t'($urandom_range(0, 6) - 3);
        it.y_offset     = smetric_t'($urandom_range(0, 6) - 3);
        it.x_advance    = smetric_t'($urandom_range(0, 26));
      end
    end else if (pick < 66) begin
      it.action    = ACT_PLACE;
      it.codepoint = CODE_NONE;
    end else if (pick < 69) begin
      it.action    = ACT_PLACE;
      it.codepoint = NEWLINE_CODE;
    end else if (pick < 72) begin
      it.action      = ACT_PLACE;
      it.glyph_found = 1'b0;
      if (it.codepoint == CODE_NONE || it.codepoint == NEWLINE_CODE) begin
        it.codepoint = code_t'(66);
      end
    end else if (pick < 79) begin
      it.action = ACT_NEWLINE;
    end else if (pick < 92) begin
      it.action = ACT_CURSOR;
      case ($urandom_range(0, 2))
        0: begin
          cx = canvas_left + $urandom_range(0, 300) - 20;
          cy = $urandom_range(0, 600) - 60;
          it.cursor_x = coord_t'(cx);
          it.cursor_y = coord_t'(cy);
        end
        1: begin
          cx = canvas_right - $urandom_range(0, 40);
          cy = canvas_bottom - $urandom_range(0, 60);
          it.cursor_x = coord_t'(cx);
          it.cursor_y = coord_t'(cy);
        end
        default: ;
      endcase
    end else if (pick < 95) begin
      it.action = ACT_USED_RESET;
    end
    return it;
  endfunction

  // sender works in bursts; valid stays high across back-to-back beats
  task automatic send_item(in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= COORD_BITS'(val);
    do @(posedge clk); while (cfg_ready !== 1'b1);
  endtask

  task automatic set_config(int bl, int bt, int br, int bb, int lh,
                            logic [1:0] rm, logic bm);
    canvas_left   = bl;
    canvas_right  = br;
    canvas_bottom = bb;
    write_reg(REG_BOX_LEFT, bl);
    write_reg(REG_BOX_TOP, bt);
    write_reg(REG_BOX_RIGHT, br);
    write_reg(REG_BOX_BOTTOM, bb);
    write_reg(REG_LINE_HEIGHT, lh);
    write_reg(REG_RIGHT_MODE, int'(rm));
    write_reg(REG_BOTTOM_MODE, int'(bm));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int bl, br;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // wrap mode with a small canvas
    set_config(10, 5, 200, 120, 16, RIGHT_WRAP, BOTTOM_TRIM);
    send_item(mk_cursor(10, 20));
    send_item(mk_glyph(65, 1, 8, 12, 0, 0, 9, 0));
    send_item(mk_glyph(66, 1, 8, 12, 0, -4, 9, -2));
    send_item(mk_glyph(0, 1, 8, 12, 0, 0, 9, 0));
    send_item(mk_glyph(int'(NEWLINE_CODE), 1, 8, 12, 0, 0, 9, 0));
    send_item(mk_ctrl(ACT_NEWLINE));
    send_item(mk_glyph(67, 0, 8, 12, 0, 0, 9, 0));
    send_item(mk_cursor(190, 20));
    send_item(mk_glyph(68, 1, 20, 12, 0, 0, 21, 3));
    send_item(mk_glyph(21'h1FFFFF, 1, 255, 255, -128, 127, 127, 127));
    send_item(mk_ctrl(ACT_USED_RESET));
    send_item(mk_glyph(70, 1, 0, 0, 127, -128, -128, -128));
    // saturation at both ends of the coordinate range
    send_item(mk_cursor(32767, 32767));
    send_item(mk_glyph(71, 1, 255, 255, 127, 127, 127, 127));
    send_item(mk_cursor(-32768, -32768));
    send_item(mk_glyph(72, 1, 255, 255, -128, -128, -128, -128));

    wait_idle();
    set_config(10, 5, 200, 120, 16, RIGHT_TRIM, BOTTOM_ERROR);
    send_item(mk_cursor(190, 20));
    send_item(mk_glyph(73, 1, 20, 12, 0, 0, 9, 0));
    send_item(mk_cursor(205, 20));
    send_item(mk_glyph(74, 1, 4, 12, 0, 0, 9, 0));
    send_item(mk_cursor(20, 115));
    send_item(mk_glyph(75, 1, 4, 10, 0, 0, 9, 0));

    wait_idle();
    set_config(10, 5, 200, 120, 16, RIGHT_ERROR, BOTTOM_TRIM);
    send_item(mk_cursor(190, 20));
    send_item(mk_glyph(76, 1, 20, 12, 0, 0, 9, 0));
    send_item(mk_cursor(20, 130));
    send_item(mk_glyph(77, 1, 4, 4, 0, 0, 9, 0));

    wait_idle();
    set_config(10, 5, 200, 120, 16, RIGHT_NONE, BOTTOM_TRIM);
    send_item(mk_cursor(190, 20));
    send_item(mk_glyph(78, 1, 20, 12, 0, 0, 9, 0));

    for (int phase = 0; phase < 8; phase++) begin
      wait_idle();
      if (phase == 0) begin
        set_config(int'(COORD_MIN), $urandom_range(0, 65535), int'(COORD_MAX),
                   int'(COORD_MAX), 255, RIGHT_WRAP, BOTTOM_TRIM);
      end else if (phase == 1) begin
        set_config(int'(COORD_MAX), $urandom_range(0, 65535), int'(COORD_MIN),
                   int'(COORD_MIN), 0, RIGHT_NONE, BOTTOM_ERROR);
      end else begin
        bl = $urandom_range(0, 200) - 100;
        br = bl + $urandom_range(20, 600);
        set_config(bl, $urandom_range(0, 65535), br, $urandom_range(50, 800),
                   ($urandom_range(0, 1) == 0) ? $urandom_range(8, 40)
                                               : $urandom_range(0, 255),
                   2'(phase % 4), 1'((phase / 4) % 2));
      end
      repeat (50) send_item(rand_layout_item());
    end

    wait_idle();
    if (errors == 0) begin
      $display("glyph_layout_cursor_engine_tb: done, clean");
    end else begin
      $display("glyph_layout_cursor_engine_tb: done, errors");
    end
    $finish;
  end

endmodule
